FILE: rtl/ldn_pkg.sv
package ldn_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int LEN_W     = 9;
    localparam int IDX_W     = 8;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Broadcast from the control to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] idx;
    } cell_ctrl_t;

endpackage

FILE: rtl/ldn_req_if.sv
interface ldn_req_if
    import ldn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [DATA_W-1:0] value;
    logic        [POS_W-1:0]  position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface

FILE: rtl/ldn_rsp_if.sv
interface ldn_rsp_if
    import ldn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic        [LEN_W-1:0]  length;

    modport source (output valid, output status, output removed_value, output length,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input length,
                    output ready);
endinterface

FILE: rtl/list_delete_nth_from_end.sv
// Bounded ordered list with delete by position counted from the tail.
//
// Channels: req (sink) carries action, value and position; rsp (source)
// carries status, removed_value and length. A beat moves when valid and
// ready are both high at a rising edge of clk.
//
// Each request beat yields exactly one response beat. The list lives in a
// chain of DEPTH cells, one entry each; on an insert every cell takes its
// left neighbor, on a delete every cell at or behind the removed place takes
// its right neighbor. All cells move in the same cycle.
//
// The response is registered and shows in the cycle after the request is
// taken. One item per cycle is accepted while rsp is ready.
//
// The response register parts the two sides: req.ready is high when that
// register is empty or being drained, so a stalled receiver holds the current
// response and stops new requests until it takes that beat.
//
// Reset (rst_n low, asynchronous) empties the list and drops any pending
// response. Cell contents are not cleared; only entries below the length are ever read.
module list_delete_nth_from_end
    import ldn_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ldn_req_if.sink   req,
    ldn_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [DATA_W-1:0] removed_reg;
    logic [DATA_W-1:0] removed_next;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;

    logic              take;
    logic [LEN_W-1:0]  count_len;
    logic [LEN_W-1:0]  pos_len;
    logic [LEN_W-1:0]  diff;
    logic              full;
    logic              empty;
    logic              pos_ok;
    logic              ins_ok;
    logic              del_ok;
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] sel_or;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_sel  [DEPTH];

    // Accept a new request whenever the response register is free or draining.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    assign count_len = LEN_W'(count_reg);
    assign pos_len   = LEN_W'(req.position);
    assign diff      = count_len - pos_len;
    assign full      = (count_len >= DEPTH_LEN);
    assign empty     = (count_len == '0);
    assign pos_ok    = (pos_len != '0) && (pos_len <= count_len);
    assign ins_ok    = (req.action == ACT_INSERT) && !full;
    assign del_ok    = (req.action == ACT_DELETE) && !empty && pos_ok;

    // Broadcast the move to the chain; idx is the removed place from the head.
    assign ctrl.ins = take && ins_ok;
    assign ctrl.del = take && del_ok;
    assign ctrl.idx = diff[IDX_W-1:0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;

            if (g == 0)
            begin : g_head
                assign left_d = req.value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign right_d = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end

            ldn_cell #(
                .IDX (g)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .left  (left_d),
                .right (right_d),
                .data  (cell_data[g]),
                .sel   (cell_sel[g])
            );
        end
    endgenerate

    // Gather the addressed entry; only one cell drives a nonzero word.
    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_or = sel_or | cell_sel[i];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        length_next    = length_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (take)
        begin
            rsp_valid_next = 1'b1;
            removed_next   = '0;
            if (req.action == ACT_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else if (!pos_ok)
            begin
                status_next = ST_BADPOS;
            end
            else
            begin
                status_next  = ST_OK;
                removed_next = sel_or;
                count_next   = count_reg - CNT_W'(1);
            end
            length_next = LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the response payload until the receiver takes it.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        length_reg  <= length_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.length        = length_reg;

endmodule

FILE: rtl/ldn_cell.sv
module ldn_cell
    import ldn_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] sel
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            data_next = left;
        end
        else if (ctrl.del && (MY_IDX >= ctrl.idx))
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign sel  = (MY_IDX == ctrl.idx) ? data_reg : '0;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

// Bench for the bounded list with delete by position counted from the tail.
// The sender drives req beats at falling edges and the receiver drives
// rsp.ready at falling edges. One checker process samples both channels at
// every rising edge: it folds each accepted req beat into a local copy of the
// list, queues the reply that beat must produce, and compares each rsp beat
// with the oldest queued reply.
module tb_top;
    import ldn_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    // Longest quiet stretch of a correct run is the receiver hold-off plus a
    // few idle draws; allow several times that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;

    // How the sender picks the position of a beat once it knows the length.
    typedef enum {
        PICK_FIXED,
        PICK_LIVE,
        PICK_ZERO,
        PICK_BEYOND,
        PICK_ANY
    } pos_pick_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] removed;
        logic        [LEN_W-1:0]  length;
    } list_reply_t;

    logic clk;
    logic rst_n;

    ldn_req_if req_if ();
    ldn_rsp_if rsp_if ();

    list_delete_nth_from_end #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    // Local copy of the list, head at index 0, and the replies still owed.
    logic signed [DATA_W-1:0] list_vals[$];
    list_reply_t              expected_replies[$];
    int                       mismatch_count = 0;

    // Idle controls shared between the test tasks and the two drivers.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int hold_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one request to the local list and return the reply it owes.
    function automatic list_reply_t apply_list_op(input action_t act,
                                                  input logic signed [DATA_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
        list_reply_t rep;
        int          len;
        int          idx;
        len         = list_vals.size();
        rep.status  = ST_OK;
        rep.removed = '0;
        if (act == ACT_INSERT)
        begin
            // A full list refuses the value and stays as it is.
            if (len >= LIST_DEPTH)
                rep.status = ST_FULL;
            else
                list_vals.push_front(val);
        end
        else if (len == 0)
        begin
            // Empty wins over any position check.
            rep.status = ST_EMPTY;
        end
        else if (pos < 1 || int'(pos) > len)
        begin
            rep.status = ST_BADPOS;
        end
        else
        begin
            idx         = len - int'(pos);
            rep.removed = list_vals[idx];
            list_vals.delete(idx);
        end
        rep.length = LEN_W'(list_vals.size());
        return rep;
    endfunction

    // Checker: compare each rsp beat first, then fold in this edge's req beat.
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: reply beat with nothing expected: status %0d removed %0d len %0d",
                             $time, rsp_if.status, rsp_if.removed_value, rsp_if.length);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_if.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.removed_value !== want.removed)
                    begin
                        $display("%0t: removed_value expected %0d actual %0d",
                                 $time, want.removed, rsp_if.removed_value);
                        mismatch_count++;
                    end
                    if (rsp_if.length !== want.length)
                    begin
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.length, rsp_if.length);
                        mismatch_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
                expected_replies.push_back(apply_list_op(action_t'(req_if.action),
                                                         req_if.value, req_if.position));
        end
    end

    // Receiver: per beat, draw a random stall when idling is on, then take the beat.
    // A pending hold request drops ready for a long stretch counted here.
    initial
    begin
        int gap;
        int hold;
        rsp_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                hold         = hold_request;
                hold_request = 0;
                @(negedge clk);
                rsp_if.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            gap = recv_idle_on ? $urandom_range(0, 11) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    // Watchdog: end the run when neither channel moves a beat for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Send one request beat. The position is picked after the idle gap, at a
    // falling edge, so the local list already holds every earlier beat.
    task automatic send_op(input action_t act, input logic signed [DATA_W-1:0] val,
                           input pos_pick_t pick, input logic [POS_W-1:0] pos_fixed);
        int               gap;
        int               len;
        logic [POS_W-1:0] pos;
        gap = send_idle_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        len = list_vals.size();
        case (pick)
            PICK_FIXED:  pos = pos_fixed;
            PICK_LIVE:   pos = (len == 0) ? POS_W'($urandom_range(0, 255))
                                          : POS_W'($urandom_range(1, len));
            PICK_ZERO:   pos = '0;
            PICK_BEYOND: pos = POS_W'($urandom_range(len + 1, 255));
            default:     pos = POS_W'($urandom_range(0, 255));
        endcase
        req_if.valid    <= 1'b1;
        req_if.action   <= act;
        req_if.value    <= val;
        req_if.position <= pos;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Drop valid and hold until every owed reply has come back.
    task automatic wait_all_replies();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
    endtask

    // Random traffic; the insert share shifts every 40 beats so the list
    // drifts between empty and full instead of hovering mid-range.
    task automatic run_mixed_traffic(input int count);
        int        ins_pct;
        int        r;
        action_t   act;
        pos_pick_t pick;
        ins_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    default: ins_pct = 75;
                endcase
            end
            act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
            r   = $urandom_range(0, 99);
            if (r < 80)
                pick = PICK_LIVE;
            else if (r < 87)
                pick = PICK_ZERO;
            else if (r < 94)
                pick = PICK_BEYOND;
            else
                pick = PICK_ANY;
            send_op(act, $urandom, pick, '0);
        end
    endtask

    // Deletes on an empty list, including position zero: empty must win.
    task automatic test_empty_deletes();
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'd0);
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'd255);
    endtask

    // Fill with the value extremes and alternating bit patterns, then push
    // one more so the full list refuses it.
    task automatic test_fill_extremes();
        send_op(ACT_INSERT, 32'sh8000_0000, PICK_FIXED, 8'd0);
        send_op(ACT_INSERT, 32'sh7FFF_FFFF, PICK_FIXED, 8'd255);
        send_op(ACT_INSERT, 32'sh0000_0000, PICK_FIXED, 8'd0);
        send_op(ACT_INSERT, 32'shFFFF_FFFF, PICK_FIXED, 8'd0);
        send_op(ACT_INSERT, 32'sh5555_5555, PICK_FIXED, 8'd0);
        send_op(ACT_INSERT, 32'shAAAA_AAAA, PICK_FIXED, 8'd0);
        for (int i = 6; i < LIST_DEPTH; i++)
            send_op(ACT_INSERT, $urandom, PICK_FIXED, 8'd0);
        send_op(ACT_INSERT, $urandom, PICK_FIXED, 8'd0);
    endtask

    // On the full list: invalid positions, the head, the tail, the middle.
    task automatic test_delete_cases();
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'd0);
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'd255);
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'(LIST_DEPTH));
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'(LIST_DEPTH));
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'd1);
        send_op(ACT_DELETE, $urandom, PICK_FIXED, 8'd7);
    endtask

    // No idling on either side: one beat per cycle.
    task automatic test_back_to_back(input int count);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        run_mixed_traffic(count);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering,
    // so the block fills and stalls its request side.
    task automatic test_receiver_holdoff(input int count);
        send_idle_on = 1'b0;
        hold_request = HOLDOFF_CYCLES;
        run_mixed_traffic(count);
        send_idle_on = 1'b1;
    endtask

    // Pause the sender until every reply is back, then resume.
    task automatic test_drain_pause(input int count);
        wait_all_replies();
        run_mixed_traffic(count);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.action   <= ACT_INSERT;
        req_if.value    <= '0;
        req_if.position <= '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_deletes();
        test_fill_extremes();
        test_delete_cases();
        run_mixed_traffic(600);
        test_back_to_back(150);
        test_receiver_holdoff(24);
        test_drain_pause(200);

        // Let the last replies land, then allow for the registered response.
        wait_all_replies();
        repeat (4) @(posedge clk);
        if (expected_replies.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, expected_replies.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ldn_pkg.sv
rtl/ldn_req_if.sv
rtl/ldn_rsp_if.sv
rtl/ldn_cell.sv
rtl/list_delete_nth_from_end.sv
bench/tb_top.sv
